[design/fqr_pkg.sv]
// Shared constants and request/status codes for the rotating FIFO queue.
`default_nettype none

package fqr_pkg;

    // Fixed field widths of the request and result beats.
    localparam int ACT_W  = 2;
    localparam int VAL_W  = 32;
    localparam int AMT_W  = 16;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 9;

    // Request codes.
    localparam logic [ACT_W-1:0] ACT_ENQ = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DEQ = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ROT = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Value returned by a dequeue from an empty queue.
    localparam logic [VAL_W-1:0] EMPTY_VALUE = '1;

endpackage

`default_nettype wire

[design/fqr_ram.sv]
// Entry store of the queue: one write port, one read port, registered read data.
`default_nettype none

module fqr_ram #(
    parameter int DEPTH = 256,
    parameter int PW    = 8
) (
    input  wire                          i_clk,
    input  wire                          i_wr_en,
    input  wire  [PW-1:0]                i_wr_addr,
    input  wire  [fqr_pkg::VAL_W-1:0]    i_wr_data,
    input  wire                          i_rd_en,
    input  wire  [PW-1:0]                i_rd_addr,
    output logic [fqr_pkg::VAL_W-1:0]    o_rd_data
);

    logic [fqr_pkg::VAL_W-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; the read data is registered.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[design/fqr_mod.sv]
// Bit-serial remainder unit: rotate amount modulo the current item count.
`default_nettype none

module fqr_mod #(
    parameter int CW = 9
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire  [fqr_pkg::AMT_W-1:0]  i_dividend,
    input  wire  [CW-1:0]              i_divisor,
    output logic                       o_done,
    output logic [CW-1:0]              o_rem
);

    localparam int BW = $clog2(fqr_pkg::AMT_W);

    logic                       r_busy;
    logic                       r_done;
    logic [BW-1:0]              r_bit;
    logic [fqr_pkg::AMT_W-1:0]  r_dvd;
    logic [CW-1:0]              r_rem;
    logic [CW:0]                shifted;
    logic [CW:0]                reduced;

    // One restoring step: bring in the next dividend bit, subtract if it fits.
    always_comb begin
        shifted = {r_rem, r_dvd[r_bit]};
        reduced = (shifted >= {1'b0, i_divisor}) ? (shifted - {1'b0, i_divisor}) : shifted;
    end

    // Control: one dividend bit per cycle, most significant first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_bit <= BW'(fqr_pkg::AMT_W - 1);
        end else if (r_busy) begin
            r_rem <= reduced[CW-1:0];
            r_bit <= r_bit - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

[design/fifo_queue_with_rotate.sv]
// Top level of the FIFO queue with enqueue, dequeue and rotate-by-k requests.
//
//  channel   | handshake           | fields
//  ----------+---------------------+-----------------------------------------
//  request   | start / busy        | i_action, i_value, i_amount
//  result    | o_done (one cycle)  | o_read_value, o_status, o_occupancy
//
// A request is taken when start is high and busy is low; each request gives one
// result beat, shown for one cycle with o_done. Enqueue answers from idle. Dequeue
// reads the head in idle and answers from the dequeue state with the store's
// registered read data. A rotate moves k = amount mod count entries; it goes to the
// rotate state at once when the amount is below the count, else it waits first in
// the remainder state for the bit-serial remainder unit. One entry moves per cycle
// through the store. Empty-queue requests, full enqueues and the unused code answer from idle.
// Reset is synchronous and empties the queue; the store itself is not cleared.
// The receiver cannot stall, so results never wait.
`default_nettype none

module fifo_queue_with_rotate #(
    parameter int DEPTH = 256
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire  [fqr_pkg::ACT_W-1:0]           i_action,
    input  wire  signed [fqr_pkg::VAL_W-1:0]    i_value,
    input  wire  [fqr_pkg::AMT_W-1:0]           i_amount,
    output logic                                o_done,
    output logic signed [fqr_pkg::VAL_W-1:0]    o_read_value,
    output logic [fqr_pkg::STAT_W-1:0]          o_status,
    output logic [fqr_pkg::OCC_W-1:0]           o_occupancy
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > fqr_pkg::AMT_W) ? CW : fqr_pkg::AMT_W;
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEQ,
        S_MOD,
        S_ROT
    } t_state;

    t_state                         r_state, n_state;
    logic [PW-1:0]                  r_head, n_head;
    logic [PW-1:0]                  r_tail, n_tail;
    logic [CW-1:0]                  r_count, n_count;
    logic [CW-1:0]                  r_left, n_left;
    logic                           r_pend, n_pend;
    logic                           r_done, n_done;
    logic [fqr_pkg::VAL_W-1:0]      r_rdv, n_rdv;
    logic [fqr_pkg::STAT_W-1:0]     r_status, n_status;
    logic [fqr_pkg::OCC_W-1:0]      r_occ, n_occ;

    logic                           wr_en;
    logic [fqr_pkg::VAL_W-1:0]      wr_data;
    logic                           rd_en;
    logic [fqr_pkg::VAL_W-1:0]      rd_data;
    logic                           mod_start;
    logic                           mod_done;
    logic [CW-1:0]                  mod_rem;
    logic [PW-1:0]                  head_next;
    logic [PW-1:0]                  tail_next;
    logic                           is_empty;
    logic                           is_full;
    logic                           amt_small;

    // Ring pointer advance and occupancy flags.
    assign head_next = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign tail_next = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
    assign is_empty  = (r_count == '0);
    assign is_full   = (r_count == FULL_CNT);
    assign amt_small = (MW'(i_amount) < MW'(r_count));

    // Entry store: reads always at the head, writes always at the tail.
    fqr_ram #(
        .DEPTH (DEPTH),
        .PW    (PW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_head),
        .o_rd_data (rd_data)
    );

    // Remainder of the rotate amount by the count.
    fqr_mod #(
        .CW (CW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (i_amount),
        .i_divisor  (r_count),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // Request sequencing and result formation.
    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_left    = r_left;
        n_pend    = r_pend;
        n_done    = 1'b0;
        n_rdv     = r_rdv;
        n_status  = r_status;
        n_occ     = r_occ;
        wr_en     = 1'b0;
        wr_data   = i_value;
        rd_en     = 1'b0;
        mod_start = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_rdv    = '0;
                    n_status = fqr_pkg::ST_OK;
                    n_occ    = fqr_pkg::OCC_W'(r_count);
                    case (i_action)
                        fqr_pkg::ACT_ENQ: begin
                            n_done = 1'b1;
                            if (is_full) begin
                                n_status = fqr_pkg::ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                n_tail  = tail_next;
                                n_count = r_count + 1'b1;
                                n_occ   = fqr_pkg::OCC_W'(r_count + 1'b1);
                            end
                        end
                        fqr_pkg::ACT_DEQ: begin
                            if (is_empty) begin
                                n_done   = 1'b1;
                                n_rdv    = fqr_pkg::EMPTY_VALUE;
                                n_status = fqr_pkg::ST_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                n_state = S_DEQ;
                            end
                        end
                        fqr_pkg::ACT_ROT: begin
                            if (is_empty) begin
                                n_done   = 1'b1;
                                n_status = fqr_pkg::ST_EMPTY;
                            end else if (amt_small) begin
                                n_left  = CW'(i_amount);
                                n_pend  = 1'b0;
                                n_state = S_ROT;
                            end else begin
                                mod_start = 1'b1;
                                n_state   = S_MOD;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_DEQ: begin
                n_done   = 1'b1;
                n_rdv    = rd_data;
                n_head   = head_next;
                n_count  = r_count - 1'b1;
                n_occ    = fqr_pkg::OCC_W'(r_count - 1'b1);
                n_state  = S_IDLE;
            end
            S_MOD: begin
                if (mod_done) begin
                    n_left  = mod_rem;
                    n_pend  = 1'b0;
                    n_state = S_ROT;
                end
            end
            S_ROT: begin
                // Read the head entry; write the one read last cycle at the tail.
                if (r_left != '0) begin
                    rd_en  = 1'b1;
                    n_head = head_next;
                    n_left = r_left - 1'b1;
                end
                n_pend = (r_left != '0);
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_data = rd_data;
                    n_tail  = tail_next;
                end
                if (r_left == '0 && !r_pend) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, pointers and registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
        r_left   <= n_left;
        r_rdv    <= n_rdv;
        r_status <= n_status;
        r_occ    <= n_occ;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_read_value = r_rdv;
    assign o_status     = r_status;
    assign o_occupancy  = r_occ;

endmodule

`default_nettype wire
